FILE: design/grt_pkg.sv
package grt_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RECIP_W,
        S_TD_GO,
        S_TD_W,
        S_STEP,
        S_CHECK,
        S_SAMP_GO,
        S_SAMP_W,
        S_ADDR,
        S_READ,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        L_IDLE,
        L_DIV,
        L_TDIST,
        L_SAMPLE
    } t_lane_mode;

    typedef struct packed {
        logic load;
        logic tdist;
        logic sample;
        logic advance;
    } t_lane_ctl;

    typedef struct packed {
        logic busy;
        logic neg;
    } t_lane_sts;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_WALL  = 2'd1;
    localparam logic [1:0] KIND_DOOR  = 2'd2;
    localparam logic [1:0] KIND_LIGHT = 2'd3;

    localparam logic [1:0] FACE_NEG_X = 2'd0;
    localparam logic [1:0] FACE_POS_X = 2'd1;
    localparam logic [1:0] FACE_NEG_Y = 2'd2;
    localparam logic [1:0] FACE_POS_Y = 2'd3;

    localparam int ORG_W       = 16;
    localparam int DIR_W       = 16;
    localparam int INDEX_W     = 12;
    localparam int INV_W       = 33;
    localparam int INV_BITS    = 16;
    localparam int CHUNK_W     = 17;
    localparam int NEXT_W      = 12;
    localparam int CELL_W      = 16;
    localparam int QUOT_W      = 31;
    localparam int NUDGE_SHIFT = 13;
    localparam int DIR_FRAC    = 14;
    localparam int DIST_W      = 17;

    localparam logic [INV_W-1:0]  ZERO_DIR_INV = 33'd6553600000;
    localparam logic [DIST_W-1:0] DIST_LIMIT   = 17'h1FFFF;

endpackage

FILE: design/grt_div.sv
module grt_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [grt_pkg::DIR_W-1:0]       i_den,
    output logic                            o_busy,
    output logic [grt_pkg::QUOT_W-1:0]      o_quot
);
    import grt_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIR_W:0]     r_rem;
    logic [DIR_W-1:0]   r_den;
    logic [QUOT_W-1:0]  r_quot;
    logic [DIR_W:0]     w_shift;
    logic               w_ge;

    // dividend is 2^30: only the first shifted-in bit is one
    assign w_shift = {r_rem[DIR_W-1:0], (r_cnt == '0)};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

FILE: design/grt_axis.sv
module grt_axis #(
    parameter int FRAC = 10
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  grt_pkg::t_lane_ctl                      i_ctl,
    input  logic [grt_pkg::ORG_W-1:0]               i_org,
    input  logic signed [grt_pkg::DIR_W-1:0]        i_dir,
    input  logic [FRAC+12+grt_pkg::INV_W:0]         i_tn,
    output grt_pkg::t_lane_sts                      o_sts,
    output logic [FRAC+12+grt_pkg::INV_W-1:0]       o_t,
    output logic signed [grt_pkg::NEXT_W-1:0]       o_next,
    output logic signed [grt_pkg::CELL_W-1:0]       o_cell
);
    import grt_pkg::*;

    localparam int DM    = FRAC + 12;
    localparam int TW    = DM + INV_W;
    localparam int TNW   = TW + 1;
    localparam int SW    = TNW + DIR_W;
    localparam int HIW   = TNW - INV_BITS;
    localparam int NSC   = (HIW + CHUNK_W - 1) / CHUNK_W;
    localparam int PADW  = NSC * CHUNK_W;
    localparam int CNW   = $clog2(NSC + 1);
    localparam int CIW   = $clog2(NSC);
    localparam int PRW   = DM + CHUNK_W;
    localparam int MW    = FRAC + 13;
    localparam int PW    = FRAC + 15;

    t_lane_mode                 r_mode;
    logic [CNW-1:0]             r_cnt;
    logic [ORG_W-1:0]           r_org;
    logic                       r_neg;
    logic [DIR_W-1:0]           r_ad;
    logic [INV_W-1:0]           r_inv;
    logic signed [NEXT_W-1:0]   r_next;
    logic [TNW-1:0]             r_tn;
    logic [SW-1:0]              r_acc;
    logic [TW-1:0]              r_t;
    logic signed [CELL_W-1:0]   r_cell;

    logic                       w_div_busy;
    logic [QUOT_W-1:0]          w_quot;
    logic [DIR_W-1:0]           w_ad_in;
    logic [ORG_W:0]             w_org_up;
    logic signed [NEXT_W-1:0]   w_next_init;
    logic signed [DM:0]         w_nscaled;
    logic signed [DM:0]         w_delta;
    logic [DM-1:0]              w_dmag;
    logic [PADW-1:0]            w_tn_pad;
    logic [CHUNK_W-1:0]         w_chunk [NSC];
    logic [CIW-1:0]             w_cidx;
    logic [6:0]                 w_shamt;
    logic [DM-1:0]              w_a;
    logic [CHUNK_W-1:0]         w_b;
    logic [PRW-1:0]             w_prod;
    logic [SW-1:0]              w_acc_next;
    logic [MW-1:0]              w_m;
    logic signed [PW-1:0]       w_pos;
    logic [PW-1:0]              w_pabs;
    logic [PW-1:0]              w_q;
    logic signed [CELL_W-1:0]   w_cell;

    assign w_ad_in  = i_dir[DIR_W-1] ? DIR_W'(-i_dir) : DIR_W'(i_dir);
    assign w_org_up = {1'b0, i_org} + (ORG_W+1)'((1 << FRAC) - 1);
    assign w_next_init = i_dir[DIR_W-1]
        ? NEXT_W'(w_org_up >> FRAC) - NEXT_W'(1)
        : NEXT_W'(i_org >> FRAC) + NEXT_W'(1);

    grt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.load),
        .i_den   (w_ad_in),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // boundary offset from origin
    assign w_nscaled = {{(DM+1-NEXT_W-FRAC){r_next[NEXT_W-1]}}, r_next, {FRAC{1'b0}}};
    assign w_delta   = w_nscaled - $signed({{(DM+1-ORG_W){1'b0}}, r_org});
    assign w_dmag    = w_delta[DM] ? DM'(-w_delta) : DM'(w_delta);

    assign w_tn_pad = PADW'(r_tn >> INV_BITS);
    for (genvar k = 0; k < NSC; k++) begin : g_chunk
        assign w_chunk[k] = w_tn_pad[k*CHUNK_W +: CHUNK_W];
    end
    assign w_cidx  = CIW'(r_cnt - 1'b1);
    assign w_shamt = 7'(w_cidx) * 7'(CHUNK_W);

    always_comb begin
        if (r_mode == L_TDIST) begin
            w_a = w_dmag;
            w_b = (r_cnt == '0) ? r_inv[CHUNK_W-1:0] : {1'b0, r_inv[INV_W-1:CHUNK_W]};
        end else begin
            w_a = DM'(r_ad);
            w_b = (r_cnt == '0) ? {1'b0, r_tn[INV_BITS-1:0]} : w_chunk[w_cidx];
        end
    end

    assign w_prod = PRW'(w_a) * PRW'(w_b);

    always_comb begin
        if (r_mode == L_TDIST) begin
            w_acc_next = (r_cnt == '0) ? SW'(w_prod) : r_acc + (SW'(w_prod) << CHUNK_W);
        end else begin
            w_acc_next = (r_cnt == '0) ? SW'(w_prod >> INV_BITS)
                                       : r_acc + (SW'(w_prod) << w_shamt);
        end
    end

    // sample point, truncated toward zero
    assign w_m    = MW'(w_acc_next >> DIR_FRAC);
    assign w_pos  = r_neg ? $signed(PW'(r_org)) - $signed(PW'(w_m))
                          : $signed(PW'(r_org)) + $signed(PW'(w_m));
    assign w_pabs = w_pos[PW-1] ? PW'(-w_pos) : PW'(w_pos);
    assign w_q    = w_pabs >> FRAC;
    assign w_cell = w_pos[PW-1] ? -$signed({1'b0, w_q[CELL_W-2:0]})
                                :  $signed({1'b0, w_q[CELL_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= L_IDLE;
            r_cnt  <= '0;
        end else begin
            case (r_mode)
                L_IDLE: begin
                    r_cnt <= '0;
                    if (i_ctl.load) begin
                        r_mode <= L_DIV;
                    end else if (i_ctl.tdist) begin
                        r_mode <= L_TDIST;
                    end else if (i_ctl.sample) begin
                        r_mode <= L_SAMPLE;
                    end
                end
                L_DIV: begin
                    if (!w_div_busy) begin
                        r_mode <= L_IDLE;
                    end
                end
                L_TDIST: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNW'(1)) begin
                        r_mode <= L_IDLE;
                    end
                end
                L_SAMPLE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNW'(NSC)) begin
                        r_mode <= L_IDLE;
                    end
                end
                default: r_mode <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mode == L_IDLE && i_ctl.load) begin
            r_org  <= i_org;
            r_neg  <= i_dir[DIR_W-1];
            r_ad   <= w_ad_in;
            r_next <= w_next_init;
        end
        if (r_mode == L_IDLE && i_ctl.advance) begin
            r_next <= r_neg ? r_next - NEXT_W'(1) : r_next + NEXT_W'(1);
        end
        if (r_mode == L_IDLE && i_ctl.sample) begin
            r_tn <= i_tn;
        end
        if (r_mode == L_DIV && !w_div_busy) begin
            r_inv <= (r_ad == '0) ? ZERO_DIR_INV : INV_W'(w_quot);
        end
        if (r_mode == L_TDIST || r_mode == L_SAMPLE) begin
            r_acc <= w_acc_next;
        end
        if (r_mode == L_TDIST && r_cnt == CNW'(1)) begin
            r_t <= w_acc_next[TW-1:0];
        end
        if (r_mode == L_SAMPLE && r_cnt == CNW'(NSC)) begin
            r_cell <= w_cell;
        end
    end

    assign o_sts.busy = (r_mode != L_IDLE);
    assign o_sts.neg  = r_neg;
    assign o_t        = r_t;
    assign o_next     = r_next;
    assign o_cell     = r_cell;

endmodule

FILE: design/grt_map.sv
module grt_map #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  logic [1:0]          i_wr_data,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output logic [1:0]          o_rd_data,
    output logic                o_ready
);
    import grt_pkg::*;

    logic [1:0]         r_mem [DEPTH];
    logic [1:0]         r_rd_data;
    logic               r_clr_busy;
    logic [ADDR_W-1:0]  r_clr_addr;

    // clearing pass after reset, one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= KIND_EMPTY;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr_busy;

endmodule

FILE: design/grid_ray_traversal_core.sv
// write item: written into the map if the index is in range; cast item: reciprocal setup, then
// for each grid step two boundary products, a three-chunk sample product and
// one map read, then the result goes to the output register
// one item is worked on at a time; a finished result waits in the output register
// reset: a clearing pass over all MAP_COLUMNS*MAP_ROWS cells empties the map, no input
// transfer is taken until it ends
module grid_ray_traversal_core #(
    parameter int MAP_COLUMNS   = 64,
    parameter int MAP_ROWS      = 64,
    parameter int FRACTION_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // cell_index, cell_kind, origin_x, origin_y, dir_x, dir_y, zero pad
    input  logic [79:0] i_s_tdata,
    // operation
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // distance, hit_kind, wall_face, next_cell_x, next_cell_y, zero pad
    output logic [39:0] o_m_tdata,
    // hit
    output logic        o_m_tuser
);
    import grt_pkg::*;

    localparam int MAP_SIZE = MAP_COLUMNS * MAP_ROWS;
    localparam int ADDR_W   = $clog2(MAP_SIZE);
    localparam int DM       = FRACTION_BITS + 12;
    localparam int TW       = DM + INV_W;
    localparam int TNW      = TW + 1;
    localparam int IDXW     = CELL_W + 11;

    localparam logic signed [IDXW-1:0]   COLS_I = IDXW'(MAP_COLUMNS);
    localparam logic signed [IDXW-1:0]   SIZE_I = IDXW'(MAP_SIZE);
    localparam logic signed [NEXT_W-1:0] COLS_N = NEXT_W'(MAP_COLUMNS);
    localparam logic signed [NEXT_W-1:0] ROWS_N = NEXT_W'(MAP_ROWS);

    t_state r_state;
    t_state n_state;

    logic [INDEX_W-1:0]        w_cell_index;
    logic [1:0]                w_cell_kind;
    logic [ORG_W-1:0]          w_org_x;
    logic [ORG_W-1:0]          w_org_y;
    logic signed [DIR_W-1:0]   w_dir_x;
    logic signed [DIR_W-1:0]   w_dir_y;
    logic                      w_in_xfer;
    logic                      w_out_free;

    t_lane_ctl                 w_ctl_x;
    t_lane_ctl                 w_ctl_y;
    t_lane_sts                 w_sts_x;
    t_lane_sts                 w_sts_y;
    logic [TW-1:0]             w_tx;
    logic [TW-1:0]             w_ty;
    logic signed [NEXT_W-1:0]  w_nx;
    logic signed [NEXT_W-1:0]  w_ny;
    logic signed [CELL_W-1:0]  w_cx;
    logic signed [CELL_W-1:0]  w_cy;
    logic [TNW-1:0]            w_tn;
    logic [TW-1:0]             w_tmin;
    logic                      w_adv_x;
    logic                      w_adv_y;
    logic                      w_off_map;
    logic signed [IDXW-1:0]    w_idx;
    logic                      w_idx_ok;
    logic [16:0]               w_widx;
    logic                      w_wr_ok;
    logic [1:0]                w_rd_data;
    logic                      w_map_ready;
    logic                      w_wr_en;
    logic                      w_rd_en;
    logic [1:0]                w_kind;
    logic [DIST_W-1:0]         w_dist;

    logic [TW-1:0]             r_t;
    logic [1:0]                r_face;
    logic                      r_inmap;
    logic                      r_hit;
    logic [1:0]                r_kind;
    logic                      r_ov;
    logic                      r_out_hit;
    logic [39:0]               r_out_data;

    assign w_cell_index = i_s_tdata[11:0];
    assign w_cell_kind  = i_s_tdata[13:12];
    assign w_org_x      = i_s_tdata[29:14];
    assign w_org_y      = i_s_tdata[45:30];
    assign w_dir_x      = i_s_tdata[61:46];
    assign w_dir_y      = i_s_tdata[77:62];

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ov || i_m_tready;

    grt_axis #(.FRAC(FRACTION_BITS)) u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_x),
        .i_org   (w_org_x),
        .i_dir   (w_dir_x),
        .i_tn    (w_tn),
        .o_sts   (w_sts_x),
        .o_t     (w_tx),
        .o_next  (w_nx),
        .o_cell  (w_cx)
    );

    grt_axis #(.FRAC(FRACTION_BITS)) u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_y),
        .i_org   (w_org_y),
        .i_dir   (w_dir_y),
        .i_tn    (w_tn),
        .o_sts   (w_sts_y),
        .o_t     (w_ty),
        .o_next  (w_ny),
        .o_cell  (w_cy)
    );

    assign w_widx  = 17'(w_cell_index);
    assign w_wr_ok = w_widx < 17'(MAP_SIZE);

    grt_map #(.DEPTH(MAP_SIZE), .ADDR_W(ADDR_W)) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_widx[ADDR_W-1:0]),
        .i_wr_data (w_cell_kind),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data),
        .o_ready   (w_map_ready)
    );

    assign w_tmin  = (w_tx < w_ty) ? w_tx : w_ty;
    assign w_adv_x = (w_tx == w_tmin);
    assign w_adv_y = (w_ty == w_tmin);
    assign w_tn    = TNW'(r_t) + TNW'(r_t >> NUDGE_SHIFT);

    assign w_off_map = (w_nx < 0) || (w_nx > COLS_N) || (w_ny < 0) || (w_ny > ROWS_N);

    assign w_idx    = IDXW'(w_cx) + IDXW'(w_cy) * COLS_I;
    assign w_idx_ok = (w_idx >= 0) && (w_idx < SIZE_I);

    assign w_kind = r_inmap ? w_rd_data : KIND_EMPTY;
    assign w_dist = (|r_t[TW-1:INV_BITS+DIST_W]) ? DIST_LIMIT
                                                 : r_t[INV_BITS+DIST_W-1:INV_BITS];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_map_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer && i_s_tuser == OP_CAST) begin
                    n_state = S_RECIP_W;
                end
            end
            S_RECIP_W: begin
                if (!w_sts_x.busy && !w_sts_y.busy) begin
                    n_state = S_TD_GO;
                end
            end
            S_TD_GO:   n_state = S_TD_W;
            S_TD_W: begin
                if (!w_sts_x.busy && !w_sts_y.busy) begin
                    n_state = S_STEP;
                end
            end
            S_STEP:    n_state = S_CHECK;
            S_CHECK:   n_state = w_off_map ? S_EMIT : S_SAMP_GO;
            S_SAMP_GO: n_state = S_SAMP_W;
            S_SAMP_W: begin
                if (!w_sts_x.busy && !w_sts_y.busy) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR:    n_state = S_READ;
            S_READ: begin
                if (w_kind == KIND_WALL || w_kind == KIND_DOOR) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_TD_GO;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = (r_state == S_IDLE);
        w_ctl_x         = '0;
        w_ctl_y         = '0;
        w_wr_en         = 1'b0;
        w_rd_en         = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ctl_x.load = w_in_xfer && i_s_tuser == OP_CAST;
                w_ctl_y.load = w_in_xfer && i_s_tuser == OP_CAST;
                w_wr_en      = w_in_xfer && i_s_tuser == OP_WRITE && w_wr_ok;
            end
            S_TD_GO: begin
                w_ctl_x.tdist = 1'b1;
                w_ctl_y.tdist = 1'b1;
            end
            S_STEP: begin
                w_ctl_x.advance = w_adv_x;
                w_ctl_y.advance = w_adv_y;
            end
            S_SAMP_GO: begin
                w_ctl_x.sample = 1'b1;
                w_ctl_y.sample = 1'b1;
            end
            S_ADDR: begin
                w_rd_en = w_idx_ok;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_STEP: begin
                r_t <= w_tmin;
                if (w_adv_y) begin
                    r_face <= w_sts_y.neg ? FACE_NEG_Y : FACE_POS_Y;
                end else begin
                    r_face <= w_sts_x.neg ? FACE_NEG_X : FACE_POS_X;
                end
            end
            S_CHECK: begin
                r_hit  <= 1'b0;
                r_kind <= KIND_EMPTY;
            end
            S_ADDR: begin
                r_inmap <= w_idx_ok;
            end
            S_READ: begin
                r_hit  <= 1'b1;
                r_kind <= w_kind;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_out_hit  <= r_hit;
                    r_out_data <= r_hit ? {3'b000, w_ny[7:0], w_nx[7:0], r_face, r_kind, w_dist}
                                        : '0;
                end
            end
            default: begin
                r_inmap <= r_inmap;
            end
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_hit;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("miss result carries nonzero fields");

    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[18:17] == KIND_WALL ||
                                       o_m_tdata[18:17] == KIND_DOOR))
        else $error("hit result with a kind that does not stop a ray");

    a_lanes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_sts_x.busy && !w_sts_y.busy))
        else $error("axis lane busy while waiting for an item");

    a_cast_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_s_tuser == OP_CAST) |=> (r_state == S_RECIP_W && w_sts_x.busy))
        else $error("cast transfer did not start the reciprocal");

endmodule

FILE: sim/tb_grid_ray_traversal_core.sv
module tb_grid_ray_traversal_core;
    import grt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS     = 64;
    localparam int ROWS     = 64;
    localparam int FRAC     = 10;
    localparam int CELLS    = COLS * ROWS;
    localparam int N_RANDOM = 1525;

    typedef struct packed {
        logic        hit;
        logic [16:0] distance;
        logic [1:0]  hit_kind;
        logic [1:0]  wall_face;
        logic [7:0]  next_x;
        logic [7:0]  next_y;
    } t_ray_hit;

    typedef struct {
        logic        op;
        logic [11:0] index;
        logic [1:0]  kind;
        logic [15:0] org_x;
        logic [15:0] org_y;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        bit          typed;
        t_ray_hit    want;
    } t_grid_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;

    logic [1:0] grid_map [CELLS];
    t_ray_hit   pending_hits [$];
    int         error_count = 0;
    int         burst_left = 0;

    grid_ray_traversal_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint sample_axis(longint org, logic signed [15:0] d, longint tn);
        longint ad;
        longint m;
        longint pos;
        ad = (d < 0) ? -longint'(d) : longint'(d);
        m = ad * (tn >> 16) + ((ad * (tn & 64'hFFFF)) >> 16);
        m = m >> DIR_FRAC;
        pos = (d < 0) ? org - m : org + m;
        return (pos >= 0) ? (pos >> FRAC) : -((-pos) >> FRAC);
    endfunction

    function automatic longint boundary_time(longint nxt, longint org, longint inv);
        longint delta;
        delta = nxt * (64'sd1 << FRAC) - org;
        if (delta < 0) delta = -delta;
        return delta * inv;
    endfunction

    function automatic t_ray_hit trace_ray(logic [15:0] ox, logic [15:0] oy,
                                           logic signed [15:0] dx, logic signed [15:0] dy);
        t_ray_hit r;
        longint invx, invy, t, tx, ty, tn, sx, sy, nx, ny, cx, cy, idx, dist_q;
        logic [1:0] face;
        logic [1:0] kind;
        bit first;
        r = '0;
        t = 0;
        face = FACE_NEG_X;
        first = 1'b1;
        invx = (dx == 0) ? longint'(ZERO_DIR_INV) : (64'sd1 << 30) / ((dx < 0) ? -dx : dx);
        invy = (dy == 0) ? longint'(ZERO_DIR_INV) : (64'sd1 << 30) / ((dy < 0) ? -dy : dy);
        sx = (dx < 0) ? -1 : 1;
        sy = (dy < 0) ? -1 : 1;
        nx = (dx < 0) ? ((longint'(ox) + 1023) >> FRAC) - 1 : (longint'(ox) >> FRAC) + 1;
        ny = (dy < 0) ? ((longint'(oy) + 1023) >> FRAC) - 1 : (longint'(oy) >> FRAC) + 1;
        forever begin
            kind = KIND_EMPTY;
            if (!first) begin
                tn = t + (t >> NUDGE_SHIFT);
                cx = sample_axis(ox, dx, tn);
                cy = sample_axis(oy, dy, tn);
                idx = cx + cy * COLS;
                if (idx >= 0 && idx < CELLS) kind = grid_map[idx];
            end
            first = 1'b0;
            if (kind == KIND_WALL || kind == KIND_DOOR) begin
                dist_q = t >> 16;
                r.hit = 1'b1;
                r.distance = (dist_q > 131071) ? DIST_LIMIT : dist_q[16:0];
                r.hit_kind = kind;
                r.wall_face = face;
                r.next_x = nx[7:0];
                r.next_y = ny[7:0];
                return r;
            end
            tx = boundary_time(nx, ox, invx);
            ty = boundary_time(ny, oy, invy);
            t = (tx < ty) ? tx : ty;
            if (tx == t) begin
                nx += sx;
                face = (sx < 0) ? FACE_NEG_X : FACE_POS_X;
            end
            if (ty == t) begin
                ny += sy;
                face = (sy < 0) ? FACE_NEG_Y : FACE_POS_Y;
            end
            if (nx < 0 || nx > COLS || ny < 0 || ny > ROWS) return '0;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // one transfer on the slave side, with bursts and gaps
    task automatic send_cmd(t_grid_cmd c);
        int gap;
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= c.op;
        i_s_tdata <= {2'b00, c.dir_y, c.dir_x, c.org_y, c.org_x, c.kind, c.index};
        do @(posedge i_clk); while (!o_s_tready);
        if (c.op == OP_WRITE) begin
            grid_map[c.index] = c.kind;
        end else if (c.typed) begin
            pending_hits.push_back(c.want);
        end else begin
            pending_hits.push_back(trace_ray(c.org_x, c.org_y, c.dir_x, c.dir_y));
        end
        @(negedge i_clk);
    endtask

    function automatic t_grid_cmd make_write(int idx, logic [1:0] k);
        t_grid_cmd c;
        c = '{default: '0};
        c.op = OP_WRITE;
        c.index = idx[11:0];
        c.kind = k;
        c.org_x = $urandom;
        c.org_y = $urandom;
        c.dir_x = $urandom;
        c.dir_y = $urandom;
        return c;
    endfunction

    function automatic t_grid_cmd make_cast(int ox, int oy, int dx, int dy);
        t_grid_cmd c;
        c = '{default: '0};
        c.op = OP_CAST;
        c.index = $urandom;
        c.kind = $urandom;
        c.org_x = ox[15:0];
        c.org_y = oy[15:0];
        c.dir_x = dx[15:0];
        c.dir_y = dy[15:0];
        return c;
    endfunction

    // unit-length direction at a random angle, or with one component zeroed, or a random non-unit direction
    function automatic t_grid_cmd random_ray();
        real ang;
        int dx, dy;
        ang = $urandom_range(0, 62831) / 10000.0;
        dx = $rtoi(16384.0 * $cos(ang));
        dy = $rtoi(16384.0 * $sin(ang));
        case ($urandom_range(0, 9))
            0: dx = 0;
            1: dy = 0;
            2: begin
                dx = $urandom_range(0, 32768) - 16384;
                dy = $urandom_range(0, 32768) - 16384;
            end
            default: ;
        endcase
        return make_cast($urandom_range(0, 65535), $urandom_range(0, 65535), dx, dy);
    endfunction

    always @(negedge i_clk) begin
        case ($urandom_range(0, 3))
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 1) == 1);
            default: i_m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_ray_hit want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result, hit", o_m_tuser, 0);
            end else begin
                want = pending_hits.pop_front();
                if (o_m_tuser !== want.hit) report_mismatch("hit", o_m_tuser, want.hit);
                if (o_m_tdata[16:0] !== want.distance)
                    report_mismatch("distance", o_m_tdata[16:0], want.distance);
                if (o_m_tdata[18:17] !== want.hit_kind)
                    report_mismatch("hit_kind", o_m_tdata[18:17], want.hit_kind);
                if (o_m_tdata[20:19] !== want.wall_face)
                    report_mismatch("wall_face", o_m_tdata[20:19], want.wall_face);
                if (o_m_tdata[28:21] !== want.next_x)
                    report_mismatch("next_cell_x", o_m_tdata[28:21], want.next_x);
                if (o_m_tdata[36:29] !== want.next_y)
                    report_mismatch("next_cell_y", o_m_tdata[36:29], want.next_y);
                if (o_m_tdata[39:37] !== 3'b000)
                    report_mismatch("pad", o_m_tdata[39:37], 0);
            end
        end
    end

    initial begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_grid_cmd directed [$];
        t_grid_cmd c;
        int n;
        foreach (grid_map[i]) grid_map[i] = KIND_EMPTY;

        // empty map: every ray leaves with an all-zero result
        c = make_cast(0, 0, 16384, 0);
        c.typed = 1'b1;
        c.want = '0;
        directed.push_back(c);
        c = make_cast(65535, 65535, -16384, -16384);
        c.typed = 1'b1;
        c.want = '0;
        directed.push_back(c);
        c = make_cast(32768, 32768, 0, 0);
        c.typed = 1'b1;
        c.want = '0;
        directed.push_back(c);
        directed.push_back(make_write(10 + 5 * COLS, KIND_WALL));
        directed.push_back(make_write(3 + 5 * COLS, KIND_DOOR));
        directed.push_back(make_write(7 + 5 * COLS, KIND_LIGHT));
        directed.push_back(make_write(5 + 12 * COLS, KIND_WALL));
        directed.push_back(make_write(5 + 1 * COLS, KIND_DOOR));
        directed.push_back(make_write(4095, KIND_WALL));
        directed.push_back(make_write(0, KIND_WALL));
        directed.push_back(make_cast(5 * 1024 + 512, 5 * 1024 + 512, 16384, 0));
        directed.push_back(make_cast(5 * 1024 + 512, 5 * 1024 + 512, -16384, 0));
        directed.push_back(make_cast(5 * 1024 + 512, 5 * 1024 + 512, 0, 16384));
        directed.push_back(make_cast(5 * 1024 + 512, 5 * 1024 + 512, 0, -16384));
        directed.push_back(make_cast(5 * 1024 + 512, 5 * 1024 + 512, 0, 0));
        directed.push_back(make_cast(10 * 1024 + 100, 5 * 1024 + 100, 11585, 11585));
        directed.push_back(make_cast(2048, 2048, -11585, -11585));
        directed.push_back(make_cast(65535, 65535, 16384, 16384));
        directed.push_back(make_cast(62 * 1024, 63 * 1024 + 900, 11585, 11585));
        directed.push_back(make_cast(0, 0, -1, -1));
        directed.push_back(make_write(7 + 5 * COLS, KIND_EMPTY));
        directed.push_back(make_cast(1024, 5 * 1024 + 512, 16384, 1));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_cmd(directed[i]);

        for (n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                i_s_tvalid <= 1'b0;
                wait (pending_hits.size() == 0);
                @(negedge i_clk);
            end
            if ($urandom_range(0, 9) < 4) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: c = make_write($urandom_range(0, CELLS - 1), KIND_EMPTY);
                    4, 5, 6:    c = make_write($urandom_range(0, CELLS - 1), KIND_WALL);
                    7:          c = make_write($urandom_range(0, CELLS - 1), KIND_DOOR);
                    default:    c = make_write($urandom_range(0, CELLS - 1), KIND_LIGHT);
                endcase
            end else begin
                c = random_ray();
            end
            send_cmd(c);
        end
        i_s_tvalid <= 1'b0;

        wait (pending_hits.size() == 0);
        repeat (200) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
